FILE: src/trpd_pkg.sv
// Shared types and constants for the touch region press detector.
// Depends on nothing; every other file in src uses it by scoped names.
`timescale 1ns / 1ps

package trpd_pkg;

    // Widths of the coordinate and timer fields.
    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 48;

    // Hold-off length is given in milliseconds and kept in microseconds.
    localparam int US_PER_MS     = 1000;
    localparam int DBNC_MS_BITS  = 16;
    localparam int DBNC_US_BITS  = 26;

    // Derived widths.
    localparam int CENTER_BITS    = COORD_BITS + 1;
    localparam int HALF_BITS      = COORD_BITS - 1;
    localparam int RADIUS_SQ_BITS = 2 * COORD_BITS;
    localparam int CFG_DATA_BITS  = (CENTER_BITS > DBNC_MS_BITS) ? CENTER_BITS : DBNC_MS_BITS;
    localparam int CFG_INDEX_BITS = 3;

    // Stream payload layout.
    localparam int IN_FIELD_BITS  = 1 + 2 * COORD_BITS + TIME_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SHAPE    = 3'd0,
        CFG_ENABLE   = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5,
        CFG_RADIUS   = 3'd6,
        CFG_DEBOUNCE = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_READ   = 1'b1
    } t_action;

    // Configuration as seen by the datapath, with the squared radius and
    // the hold-off in microseconds already worked out at write time.
    typedef struct packed {
        logic                      shape_is_circle;
        logic                      touch_enabled;
        logic [CENTER_BITS-1:0]    center_x;
        logic [CENTER_BITS-1:0]    center_y;
        logic [HALF_BITS-1:0]      half_w;
        logic [HALF_BITS-1:0]      half_h;
        logic [RADIUS_SQ_BITS-1:0] radius_sq;
        logic [DBNC_US_BITS-1:0]   debounce_us;
    } t_cfg;

    typedef struct packed {
        t_action                action;
        logic                   touch_down;
        logic [COORD_BITS-1:0]  touch_x;
        logic [COORD_BITS-1:0]  touch_y;
        logic [TIME_BITS-1:0]   now_us;
    } t_item;

    typedef struct packed {
        logic touched;
        logic pressed;
        logic debouncing;
    } t_result;

endpackage

FILE: src/trpd_cfg_regs.sv
// Configuration register file of the touch region press detector.
// Depends on trpd_pkg for the register index codes and the t_cfg struct.
`timescale 1ns / 1ps

module trpd_cfg_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [trpd_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [trpd_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                                   o_cfg_ready,
    output trpd_pkg::t_cfg                         o_cfg
);

    trpd_pkg::t_cfg r_cfg;
    logic [trpd_pkg::COORD_BITS-1:0] w_coord;
    logic [trpd_pkg::DBNC_MS_BITS-1:0] w_ms;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign w_coord     = i_cfg_data[trpd_pkg::COORD_BITS-1:0];
    assign w_ms        = i_cfg_data[trpd_pkg::DBNC_MS_BITS-1:0];

    // Width and height are only ever used halved, so the halves are stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (trpd_pkg::t_cfg_idx'(i_cfg_index))
                trpd_pkg::CFG_SHAPE:    r_cfg.shape_is_circle <= i_cfg_data[0];
                trpd_pkg::CFG_ENABLE:   r_cfg.touch_enabled   <= i_cfg_data[0];
                trpd_pkg::CFG_CENTER_X: r_cfg.center_x <=
                    i_cfg_data[trpd_pkg::CENTER_BITS-1:0];
                trpd_pkg::CFG_CENTER_Y: r_cfg.center_y <=
                    i_cfg_data[trpd_pkg::CENTER_BITS-1:0];
                trpd_pkg::CFG_WIDTH:    r_cfg.half_w <=
                    w_coord[trpd_pkg::COORD_BITS-1:1];
                trpd_pkg::CFG_HEIGHT:   r_cfg.half_h <=
                    w_coord[trpd_pkg::COORD_BITS-1:1];
                trpd_pkg::CFG_RADIUS:   r_cfg.radius_sq <=
                    trpd_pkg::RADIUS_SQ_BITS'(w_coord) *
                    trpd_pkg::RADIUS_SQ_BITS'(w_coord);
                trpd_pkg::CFG_DEBOUNCE: r_cfg.debounce_us <=
                    trpd_pkg::DBNC_US_BITS'(w_ms) *
                    trpd_pkg::DBNC_US_BITS'(trpd_pkg::US_PER_MS);
            endcase
        end
    end

endmodule

FILE: src/trpd_region_test.sv
// Point-in-region test: rectangle with truncated half sizes or circle by
// exact squared distance. Pure combinational logic; depends on trpd_pkg.
`timescale 1ns / 1ps

module trpd_region_test (
    input  trpd_pkg::t_cfg                     i_cfg,
    input  logic [trpd_pkg::COORD_BITS-1:0]    i_x,
    input  logic [trpd_pkg::COORD_BITS-1:0]    i_y,
    output logic                               o_inside
);

    localparam int D = trpd_pkg::COORD_BITS + 2;   // signed difference width
    localparam int E = trpd_pkg::COORD_BITS + 3;   // signed rectangle bound width

    logic signed [D-1:0]   w_dx, w_dy;
    logic signed [2*D-1:0] w_sq_x, w_sq_y;
    logic [2*D:0]          w_dist_sq;
    logic                  w_in_circle;

    logic signed [E-1:0]   w_x, w_y, w_cx, w_cy, w_hw, w_hh;
    logic signed [E-1:0]   w_x_lo, w_x_hi, w_y_lo, w_y_hi;
    logic                  w_in_rect;

    // Circle: squares of the signed offsets, summed without overflow.
    assign w_dx = $signed({2'b00, i_x}) -
                  $signed({i_cfg.center_x[trpd_pkg::CENTER_BITS-1], i_cfg.center_x});
    assign w_dy = $signed({2'b00, i_y}) -
                  $signed({i_cfg.center_y[trpd_pkg::CENTER_BITS-1], i_cfg.center_y});
    assign w_sq_x = w_dx * w_dx;
    assign w_sq_y = w_dy * w_dy;
    assign w_dist_sq = {1'b0, w_sq_x} + {1'b0, w_sq_y};
    assign w_in_circle = w_dist_sq <= (2*D+1)'(i_cfg.radius_sq);

    // Rectangle: inclusive bounds around the center.
    assign w_x  = $signed({3'b000, i_x});
    assign w_y  = $signed({3'b000, i_y});
    assign w_cx = $signed({{2{i_cfg.center_x[trpd_pkg::CENTER_BITS-1]}}, i_cfg.center_x});
    assign w_cy = $signed({{2{i_cfg.center_y[trpd_pkg::CENTER_BITS-1]}}, i_cfg.center_y});
    assign w_hw = $signed({4'b0000, i_cfg.half_w});
    assign w_hh = $signed({4'b0000, i_cfg.half_h});
    assign w_x_lo = w_cx - w_hw;
    assign w_x_hi = w_cx + w_hw;
    assign w_y_lo = w_cy - w_hh;
    assign w_y_hi = w_cy + w_hh;
    assign w_in_rect = (w_x >= w_x_lo) && (w_x <= w_x_hi) &&
                       (w_y >= w_y_lo) && (w_y <= w_y_hi);

    assign o_inside = i_cfg.shape_is_circle ? w_in_circle : w_in_rect;

endmodule

FILE: src/trpd_press_logic.sv
// Press state (touched, press, read mark, hold-off window) and its update
// for one item. Depends on trpd_pkg for t_cfg, t_item and t_result.
`timescale 1ns / 1ps

module trpd_press_logic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  trpd_pkg::t_cfg       i_cfg,
    input  trpd_pkg::t_item      i_item,
    input  logic                 i_inside,
    input  logic                 i_fire,
    output trpd_pkg::t_result    o_result
);

    logic r_touched, r_press, r_was_read, r_holdoff;
    logic [trpd_pkg::TIME_BITS-1:0] r_end_us;

    logic n_touched, n_press, n_was_read, n_holdoff;
    logic [trpd_pkg::TIME_BITS-1:0] n_end_us;

    logic                           w_start;
    logic                           w_hold1, w_press1, w_read1, w_expire, w_press2;
    logic [trpd_pkg::TIME_BITS:0]   w_sum;

    // A new window ends at once when the length is zero or the end wraps.
    assign w_sum = {1'b0, i_item.now_us} + (trpd_pkg::TIME_BITS+1)'(i_cfg.debounce_us);

    always_comb begin
        n_touched  = r_touched;
        n_press    = r_press;
        n_was_read = r_was_read;
        n_holdoff  = r_holdoff;
        n_end_us   = r_end_us;
        w_start    = 1'b0;
        w_hold1    = 1'b0;
        w_press1   = 1'b0;
        w_read1    = 1'b0;
        w_expire   = 1'b0;
        w_press2   = 1'b0;
        o_result.touched    = r_touched;
        o_result.pressed    = r_press;
        o_result.debouncing = r_holdoff;

        if (i_item.action == trpd_pkg::ACT_READ) begin
            n_was_read = r_was_read | r_press;
        end else begin
            if (i_cfg.touch_enabled) begin
                n_touched = i_item.touch_down & i_inside;
            end
            w_start  = !r_press && n_touched && !r_holdoff;
            w_hold1  = r_holdoff | w_start;
            w_press1 = r_press | w_start;
            w_read1  = w_start ? 1'b0 : r_was_read;
            if (w_start) begin
                w_expire = (i_cfg.debounce_us == '0) || w_sum[trpd_pkg::TIME_BITS];
                n_end_us = w_sum[trpd_pkg::TIME_BITS-1:0];
            end else begin
                w_expire = w_hold1 && (i_item.now_us >= r_end_us);
            end
            w_press2   = w_press1 & !w_expire;
            n_holdoff  = w_hold1 & !w_expire;
            n_press    = w_press2 & !w_read1;
            n_was_read = w_read1;
            o_result.pressed = n_press;
        end
        o_result.touched    = n_touched;
        o_result.debouncing = n_holdoff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched  <= 1'b0;
            r_press    <= 1'b0;
            r_was_read <= 1'b0;
            r_holdoff  <= 1'b0;
            r_end_us   <= '0;
        end else if (i_fire) begin
            r_touched  <= n_touched;
            r_press    <= n_press;
            r_was_read <= n_was_read;
            r_holdoff  <= n_holdoff;
            r_end_us   <= n_end_us;
        end
    end

endmodule

FILE: src/touch_region_press_detector_unit.sv
// Top level of the touch region press detector: stream ports, input and
// result registers. Depends on trpd_pkg, trpd_cfg_regs, trpd_region_test
// and trpd_press_logic.
`timescale 1ns / 1ps
//
//  Channel      Direction  Handshake                  Payload
//  -----------  ---------  -------------------------  ---------------------------------
//  s_axis       in         i_s_axis_tvalid/o_..tready  tdata: item fields, tuser: action
//  m_axis       out        o_m_axis_tvalid/i_..tready  tdata: touched, pressed, debouncing
//  cfg          in         i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
//  An accepted beat lands in the input register; the hit test and press
//  update then run on it in one pass, and the result is loaded into the
//  output register once that register is free or drains, and is presented
//  on m_axis from there. One beat can be accepted every cycle while m_axis
//  does not stall.
//  Reset (i_rst_n low at a clock edge) clears all press state, the
//  configuration and both valid flags.
//  A stall on m_axis holds the output register and the input register; the
//  input side keeps accepting until the input register is also occupied.
//  Configuration writes are always accepted and take effect the next cycle.

module touch_region_press_detector_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // Bits from lowest: touch_down, touch_x, touch_y, now_us, zero padding.
    input  logic [trpd_pkg::IN_TDATA_BITS-1:0]     i_s_axis_tdata,
    // Bit 0: action (0 touch sample, 1 host read of the press state).
    input  logic                                   i_s_axis_tuser,

    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // Bits from lowest: touched, pressed, debouncing, zero padding.
    output logic [trpd_pkg::OUT_TDATA_BITS-1:0]    o_m_axis_tdata,

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [trpd_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [trpd_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int X_LO = 1;
    localparam int Y_LO = X_LO + trpd_pkg::COORD_BITS;
    localparam int T_LO = Y_LO + trpd_pkg::COORD_BITS;

    trpd_pkg::t_cfg    w_cfg;
    trpd_pkg::t_result w_result;
    trpd_pkg::t_item   r_item;
    logic              r_in_valid;
    logic              r_out_valid;
    trpd_pkg::t_result r_out;
    logic              w_fire;
    logic              w_inside;
    logic              w_accept;

    // The held item moves on whenever the output register is free or drains.
    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action     <= trpd_pkg::t_action'(i_s_axis_tuser);
            r_item.touch_down <= i_s_axis_tdata[0];
            r_item.touch_x    <= i_s_axis_tdata[Y_LO-1:X_LO];
            r_item.touch_y    <= i_s_axis_tdata[T_LO-1:Y_LO];
            r_item.now_us     <= i_s_axis_tdata[T_LO+trpd_pkg::TIME_BITS-1:T_LO];
        end
    end

    trpd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    trpd_region_test u_region_test (
        .i_cfg    (w_cfg),
        .i_x      (r_item.touch_x),
        .i_y      (r_item.touch_y),
        .o_inside (w_inside)
    );

    // Press state advances exactly when its result enters the output register.
    trpd_press_logic u_press_logic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (r_item),
        .i_inside (w_inside),
        .i_fire   (w_fire),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(trpd_pkg::OUT_TDATA_BITS-3){1'b0}},
                              r_out.debouncing, r_out.pressed, r_out.touched};

endmodule
